// File: rtl/core/plp_pkg.sv
// plp_pkg: shared constants, status and mode codes and cell control type
// for the positional insert/delete list; no dependencies
package plp_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 5;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [1:0] MODE_INS = 2'd0;
	localparam logic [1:0] MODE_DEL = 2'd1;
	localparam logic [1:0] MODE_RD  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic             ins;
		logic             del;
		logic [IDX_W-1:0] pos;
	} cell_ctrl_t;

endpackage

// File: rtl/core/plp_cell.sv
// plp_cell: one list slot; shifts up on insert, down on delete, drives
// its entry on a position match; depends on plp_pkg
module plp_cell (
	input  logic                               clk,
	input  plp_pkg::cell_ctrl_t                ctrl,
	input  logic [plp_pkg::IDX_W-1:0]          idx,
	input  logic signed [plp_pkg::DATA_W-1:0]  left_data,
	input  logic signed [plp_pkg::DATA_W-1:0]  right_data,
	input  logic signed [plp_pkg::DATA_W-1:0]  ins_data,
	output logic signed [plp_pkg::DATA_W-1:0]  data,
	output logic signed [plp_pkg::DATA_W-1:0]  rd_data
);

	logic signed [plp_pkg::DATA_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (idx > ctrl.pos) begin
				entry_q <= left_data;
			end else if (idx == ctrl.pos) begin
				entry_q <= ins_data;
			end
		end else if (ctrl.del && (idx >= ctrl.pos)) begin
			entry_q <= right_data;
		end
	end

	assign data    = entry_q;
	assign rd_data = (idx == ctrl.pos) ? entry_q : '0;

endmodule

// File: rtl/core/positional_insert_delete_list.sv
// positional_insert_delete_list: packed list of signed entries held in a
// row of plp_cell slots; depends on plp_pkg and plp_cell
// result: registered on acceptance; all cells compare and shift in parallel
// throughput: one item per cycle while the output is not stalled
// reset: count and output valid clear at once; entries undefined until written
module positional_insert_delete_list (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic [plp_pkg::POS_W-1:0]         position,
	input  logic signed [plp_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic signed [plp_pkg::DATA_W-1:0] read_data,
	output logic [plp_pkg::POS_W-1:0]         entry_count
);

	localparam int N = plp_pkg::CAPACITY;

	logic [plp_pkg::CNT_W-1:0]         count_q;
	logic [plp_pkg::CNT_W-1:0]         count_d;
	logic                              out_valid_q;
	logic [1:0]                        status_q;
	logic signed [plp_pkg::DATA_W-1:0] read_data_q;
	logic [plp_pkg::POS_W-1:0]         entry_count_q;

	logic                              fire;
	logic [1:0]                        status_d;
	logic                              ins_ok;
	logic                              del_ok;
	logic                              rd_ok;
	logic [plp_pkg::CMP_W-1:0]         pos_ext;
	logic [plp_pkg::CMP_W-1:0]         cnt_ext;
	plp_pkg::cell_ctrl_t               ctrl;
	logic signed [plp_pkg::DATA_W-1:0] rd_or;

	logic signed [plp_pkg::DATA_W-1:0] cell_data [N];
	logic signed [plp_pkg::DATA_W-1:0] cell_rd [N];

	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;
	assign pos_ext  = plp_pkg::CMP_W'(position);
	assign cnt_ext  = plp_pkg::CMP_W'(count_q);

	always_comb begin
		status_d = plp_pkg::ST_OK;
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		rd_ok    = 1'b0;
		count_d  = count_q;
		unique case (mode)
			plp_pkg::MODE_INS: begin
				if (pos_ext > cnt_ext) begin
					status_d = plp_pkg::ST_RANGE;
				end else if (count_q == plp_pkg::CNT_W'(N)) begin
					status_d = plp_pkg::ST_FULL;
				end else begin
					ins_ok  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			plp_pkg::MODE_DEL: begin
				if (count_q == '0) begin
					status_d = plp_pkg::ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					status_d = plp_pkg::ST_RANGE;
				end else begin
					del_ok  = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			plp_pkg::MODE_RD: begin
				if (count_q == '0) begin
					status_d = plp_pkg::ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					status_d = plp_pkg::ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			default: begin
				status_d = plp_pkg::ST_RANGE;
			end
		endcase
	end

	assign ctrl.ins = fire && ins_ok;
	assign ctrl.del = fire && del_ok;
	assign ctrl.pos = position[plp_pkg::IDX_W-1:0];

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic signed [plp_pkg::DATA_W-1:0] left_w;
		logic signed [plp_pkg::DATA_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_data[i-1];
		end
		if (i == N - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_data[i+1];
		end
		plp_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.idx        (plp_pkg::IDX_W'(i)),
			.left_data  (left_w),
			.right_data (right_w),
			.ins_data   (value),
			.data       (cell_data[i]),
			.rd_data    (cell_rd[i])
		);
	end

	// only the matching cell drives a nonzero word
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < N; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q      <= status_d;
			read_data_q   <= rd_ok ? rd_or : '0;
			entry_count_q <= plp_pkg::POS_W'(count_d);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_data   = read_data_q;
	assign entry_count = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= plp_pkg::CNT_W'(N))
		else $error("entry count above capacity");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not grow the list by one");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == plp_pkg::ST_FULL)) |->
		(entry_count_q == plp_pkg::POS_W'(N)))
		else $error("full status with list not full");

	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != plp_pkg::ST_OK)) |-> (read_data_q == '0))
		else $error("read data nonzero on refused item");

endmodule

// File: tb/plp_tb_pkg.sv
`timescale 1ns / 1ps
// plp_tb_pkg: list scoreboard that tracks the entries and count of the list
// and checks each returned result in order; depends on plp_pkg
package plp_tb_pkg;

	import plp_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] read_data;
		logic [POS_W-1:0]         entry_count;
	} list_result_t;

	class list_scoreboard;
		logic [DATA_W-1:0] slots [CAPACITY];
		int                held;
		list_result_t      pending_results [$];
		int                mismatches;
		int                checked;
		int                mode_seen [4];
		int                status_seen [4];

		function new();
			held        = 0;
			mismatches  = 0;
			checked     = 0;
			mode_seen   = '{default: 0};
			status_seen = '{default: 0};
			foreach (slots[k])
				slots[k] = '0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// apply one accepted request to the list copy and queue its result
		function void note_request(logic [1:0] m, logic [POS_W-1:0] p,
			logic [DATA_W-1:0] v);
			list_result_t r;
			int           pi;
			int           i;
			pi          = int'(p);
			r.status    = ST_OK;
			r.read_data = '0;
			case (m)
				MODE_INS: begin
					if (pi > held) begin
						r.status = ST_RANGE;
					end else if (held >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						for (i = held; i > pi; i--)
							slots[i] = slots[i-1];
						slots[pi] = v;
						held++;
					end
				end
				MODE_DEL: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else if (pi >= held) begin
						r.status = ST_RANGE;
					end else begin
						for (i = pi; i + 1 < held; i++)
							slots[i] = slots[i+1];
						held--;
					end
				end
				MODE_RD: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else if (pi >= held) begin
						r.status = ST_RANGE;
					end else begin
						r.read_data = slots[pi];
					end
				end
				default: begin
					r.status = ST_RANGE;
				end
			endcase
			r.entry_count = held[POS_W-1:0];
			mode_seen[m]++;
			status_seen[r.status]++;
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [DATA_W-1:0] rd,
			logic [POS_W-1:0] cnt);
			list_result_t e;
			checked++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d data %h count %0d",
						st, rd, cnt);
				return;
			end
			e = pending_results.pop_front();
			if (e.status !== st || e.read_data !== rd || e.entry_count !== cnt) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on result %0d: exp status %0d data %h count %0d, got status %0d data %h count %0d",
						checked, e.status, e.read_data, e.entry_count, st, rd, cnt);
			end
		endfunction
	endclass

endpackage

// File: tb/tb_positional_insert_delete_list.sv
`timescale 1ns / 1ps
// tb_positional_insert_delete_list: directed and random insert, delete and
// read requests with random idling; depends on plp_pkg and plp_tb_pkg
module tb_positional_insert_delete_list;

	import plp_pkg::*;
	import plp_tb_pkg::*;

	localparam int RANDOM_ITEMS = 1620;
	localparam int QUIET_ITEMS  = 200;
	localparam int CYCLE_LIMIT  = 200000;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               mode;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	logic                     out_valid;
	logic                     out_ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] read_data;
	logic [POS_W-1:0]         entry_count;

	list_scoreboard sb;
	bit             quiet;
	int             stall_left;

	positional_insert_delete_list i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.position    (position),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.read_data   (read_data),
		.entry_count (entry_count)
	);

	always #4 clk = ~clk;

	initial begin
		sb         = new();
		quiet      = 1'b0;
		stall_left = 0;
		out_ready  = 1'b0;
	end

	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 8);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(mode, position, value);
			if (out_valid && out_ready)
				sb.check_result(status, read_data, entry_count);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout with %0d results outstanding", sb.pending());
		$display("Some tests failed");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send(logic [1:0] m, logic [POS_W-1:0] p, logic [DATA_W-1:0] v);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		position <= p;
		value    <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		logic [DATA_W-1:0] edge_vals [4];
		edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
		if ($urandom_range(0, 7) == 0)
			return edge_vals[$urandom_range(0, 3)];
		return $urandom;
	endfunction

	task automatic directed_phase();
		int k;
		send(MODE_RD, 0, 0);
		send(MODE_DEL, 0, 0);
		send(MODE_INS, 1, 32'h1);
		send(MODE_UNUSED, 31, 32'hffff_ffff);
		for (k = 0; k < CAPACITY; k++) begin
			send(MODE_INS,
				POS_W'((k % 3 == 0) ? 0 :
					(k % 3 == 1) ? sb.held : $urandom_range(0, sb.held)),
				(k == 0) ? 32'h8000_0000 : (k == 1) ? 32'h7fff_ffff : $urandom);
		end
		send(MODE_INS, 16, 32'h0);
		send(MODE_INS, 17, 32'h0);
		send(MODE_RD, 16, 32'h0);
		send(MODE_RD, 0, 32'h0);
		send(MODE_RD, 15, 32'h0);
		send(MODE_DEL, 31, 32'h0);
		send(MODE_DEL, 15, 32'h0);
		send(MODE_DEL, 0, 32'h0);
		send(MODE_DEL, 5, 32'h0);
	endtask

	// alternate fill and drain bias so the list hits full and empty often
	task automatic random_phase(int n);
		int               i;
		int               r;
		int               ins_w;
		int               del_w;
		int               bias_left;
		bit               filling;
		logic [1:0]       m;
		logic [POS_W-1:0] p;
		filling   = 1'b1;
		bias_left = 0;
		for (i = 0; i < n; i++) begin
			if (i >= n - QUIET_ITEMS)
				quiet = 1'b1;
			if (bias_left == 0) begin
				filling   = !filling;
				bias_left = $urandom_range(30, 90);
			end
			bias_left--;
			ins_w = filling ? 55 : 20;
			del_w = filling ? 20 : 55;
			r     = $urandom_range(0, 99);
			if (r < 3)
				m = MODE_UNUSED;
			else if (r < 3 + ins_w)
				m = MODE_INS;
			else if (r < 3 + ins_w + del_w)
				m = MODE_DEL;
			else
				m = MODE_RD;
			if ($urandom_range(0, 99) < 15)
				p = POS_W'($urandom_range(0, 31));
			else if (m == MODE_INS)
				p = POS_W'($urandom_range(0, sb.held));
			else
				p = (sb.held > 0) ? POS_W'($urandom_range(0, sb.held - 1)) : '0;
			send(m, p, pick_value());
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		mode     = MODE_INS;
		position = '0;
		value    = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		directed_phase();
		random_phase(RANDOM_ITEMS);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		$display("%0d requests: %0d insert, %0d delete, %0d read, %0d unused mode",
			sb.checked, sb.mode_seen[MODE_INS], sb.mode_seen[MODE_DEL],
			sb.mode_seen[MODE_RD], sb.mode_seen[MODE_UNUSED]);
		$display("outcomes: %0d ok, %0d full, %0d empty, %0d out of range, %0d mismatches",
			sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY],
			sb.status_seen[ST_RANGE], sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
